>>> design/sis_pkg.sv
`timescale 1ns / 1ps
package sis_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int TOL_WIDTH       = 16;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;
	localparam int QUEUE_DEPTH     = 4;
	localparam int CASE_WIDTH      = 3;

	typedef enum logic [CASE_WIDTH-1:0] {
		CASE_GENERAL   = 3'd0,
		CASE_PARALLEL  = 3'd1,
		CASE_B_VERT    = 3'd2,
		CASE_A_VERT    = 3'd3,
		CASE_BOTH_VERT = 3'd4
	} case_code_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> design/sis_div.sv
`timescale 1ns / 1ps
module sis_div #(
	parameter int NW = 49,
	parameter int DW = 33,
	parameter int QW = 32,
	parameter int PW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  logic [PW-1:0]        pay,
	output logic                 out_valid,
	output logic signed [QW-1:0] quo,
	output logic [PW-1:0]        pay_out
);

	localparam int MW = ((NW - QW) > DW) ? (NW - QW) : DW;

	logic [NW-1:0] nm;
	logic [DW-1:0] dm;
	logic [MW-1:0] hi_ext, dm_ext;
	logic          ovf0;

	logic          vld_s [QW+1];
	logic          neg_s [QW+1];
	logic          ovf_s [QW+1];
	logic [DW-1:0] dm_s  [QW+1];
	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] lq_s  [QW+1];
	logic [PW-1:0] pay_s [QW+1];

	logic [DW-1:0] rem_n [QW+1];
	logic [QW-1:0] lq_n  [QW+1];
	logic [DW:0]   trial [QW+1];

	logic [QW-1:0]        lim, mag;
	logic signed [QW-1:0] res;

	always_comb begin
		nm     = num[NW-1] ? (~num + {{(NW-1){1'b0}}, 1'b1}) : num;
		dm     = den[DW-1] ? (~den + {{(DW-1){1'b0}}, 1'b1}) : den;
		hi_ext = MW'(nm >> QW);
		dm_ext = MW'(dm);
		// quotient magnitude would not fit in QW bits
		ovf0   = hi_ext >= dm_ext;
	end

	// one restoring step per stage: numerator bits leave the top, quotient bits enter below
	always_comb begin
		rem_n[0] = '0;
		lq_n[0]  = '0;
		trial[0] = '0;
		for (int k = 1; k <= QW; k++) begin
			trial[k] = {rem_s[k-1], lq_s[k-1][QW-1]};
			if (trial[k] >= {1'b0, dm_s[k-1]}) begin
				rem_n[k] = DW'(trial[k] - {1'b0, dm_s[k-1]});
				lq_n[k]  = {lq_s[k-1][QW-2:0], 1'b1};
			end else begin
				rem_n[k] = DW'(trial[k]);
				lq_n[k]  = {lq_s[k-1][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) vld_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= QW; k++) vld_s[k] <= vld_s[k-1];
			out_valid <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[NW-1] ^ den[DW-1];
			ovf_s[0] <= ovf0;
			dm_s[0]  <= dm;
			rem_s[0] <= DW'(nm >> QW);
			lq_s[0]  <= nm[QW-1:0];
			pay_s[0] <= pay;
			for (int k = 1; k <= QW; k++) begin
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				dm_s[k]  <= dm_s[k-1];
				rem_s[k] <= rem_n[k];
				lq_s[k]  <= lq_n[k];
				pay_s[k] <= pay_s[k-1];
			end
			quo     <= res;
			pay_out <= pay_s[QW];
		end
	end

	always_comb begin
		lim = neg_s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		mag = (ovf_s[QW] || (lq_s[QW] > lim)) ? lim : lq_s[QW];
		res = neg_s[QW] ? $signed(~mag + {{(QW-1){1'b0}}, 1'b1}) : $signed(mag);
	end

endmodule

>>> design/sis_front.sv
`timescale 1ns / 1ps
module sis_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [8*W-1:0]                in_data,
	input  logic [sis_pkg::TOL_WIDTH-1:0] tolerance,
	input  logic                          q_full,
	output logic                          push,
	output logic [10*W+1:0]               push_data
);

	localparam int TW = sis_pkg::TOL_WIDTH;

	logic           en;
	logic           vld_s1;
	logic [8*W-1:0] crd_s1;

	logic signed [W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	logic signed [W:0]   dxa, dya, dxb, dyb;
	logic [W:0]          adxa, adxb, tol_ext;
	logic                av, bv;
	logic signed [W+F:0] numa, numb;

	logic                va_out, vb_out;
	logic signed [W-1:0] qa, qb, sa, sb;
	logic [8*W:0]        paya_out;
	logic                bv_out;

	assign en       = !q_full;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s1 <= in_data;
		end
	end

	always_comb begin
		ax1 = crd_s1[0*W +: W];
		ay1 = crd_s1[1*W +: W];
		ax2 = crd_s1[2*W +: W];
		ay2 = crd_s1[3*W +: W];
		bx1 = crd_s1[4*W +: W];
		by1 = crd_s1[5*W +: W];
		bx2 = crd_s1[6*W +: W];
		by2 = crd_s1[7*W +: W];
		dxa = {ax2[W-1], ax2} - {ax1[W-1], ax1};
		dya = {ay2[W-1], ay2} - {ay1[W-1], ay1};
		dxb = {bx2[W-1], bx2} - {bx1[W-1], bx1};
		dyb = {by2[W-1], by2} - {by1[W-1], by1};
		adxa    = dxa[W] ? (~dxa + {{W{1'b0}}, 1'b1}) : dxa;
		adxb    = dxb[W] ? (~dxb + {{W{1'b0}}, 1'b1}) : dxb;
		tol_ext = {{(W+1-TW){1'b0}}, tolerance};
		// zero extent is vertical even at zero tolerance
		av   = (dxa == '0) || (adxa < tol_ext);
		bv   = (dxb == '0) || (adxb < tol_ext);
		numa = {dya, {F{1'b0}}};
		numb = {dyb, {F{1'b0}}};
	end

	sis_div #(.NW(W+1+F), .DW(W+1), .QW(W), .PW(8*W+1)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.num      (numa),
		.den      (dxa),
		.pay      ({av, crd_s1}),
		.out_valid(va_out),
		.quo      (qa),
		.pay_out  (paya_out)
	);

	sis_div #(.NW(W+1+F), .DW(W+1), .QW(W), .PW(1)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.num      (numb),
		.den      (dxb),
		.pay      (bv),
		.out_valid(vb_out),
		.quo      (qb),
		.pay_out  (bv_out)
	);

	// a vertical segment carries slope zero
	assign sa        = paya_out[8*W] ? '0 : qa;
	assign sb        = bv_out ? '0 : qb;
	assign push      = va_out && vb_out && en;
	assign push_data = {bv_out, paya_out[8*W], sb, sa, paya_out[8*W-1:0]};

endmodule

>>> design/sis_queue.sv
`timescale 1ns / 1ps
module sis_queue #(
	parameter int DWID = 322
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [DWID-1:0]    push_data,
	input  logic               pop,
	output logic [DWID-1:0]    pop_data,
	output sis_pkg::q_status_t status
);

	localparam int DEPTH = sis_pkg::QUEUE_DEPTH;
	localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic [DWID-1:0] mem_q [DEPTH];
	logic [PTRW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data     = mem_q[rd_q];
	assign status.full  = (cnt_q == CNTW'(DEPTH));
	assign status.empty = (cnt_q == '0);

endmodule

>>> design/sis_back.sv
`timescale 1ns / 1ps
module sis_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sis_pkg::TOL_WIDTH-1:0] tolerance,
	input  sis_pkg::q_status_t            q_stat,
	input  logic [10*W+1:0]               q_data,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          hit,
	output logic                          point_set,
	output logic signed [W-1:0]           cross_x,
	output logic signed [W-1:0]           cross_y,
	output sis_pkg::case_code_t           case_code
);

	localparam int TW = sis_pkg::TOL_WIDTH;
	localparam int NW = 2*W + 3;
	localparam int PW = 10*W + 4;
	localparam logic signed [2*W+1:0] CMAXW = {{(W+3){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [2*W+1:0] CMINW = {{(W+3){1'b1}}, {(W-1){1'b0}}};

	logic en;

	function automatic logic in_rng(input logic signed [W-1:0] v, input logic signed [W-1:0] p,
			input logic signed [W-1:0] q, input logic [TW-1:0] t);
		logic signed [W-1:0] lo, hi;
		logic signed [W+1:0] tt, e1, e2;
		begin
			lo = (p < q) ? p : q;
			hi = (p < q) ? q : p;
			tt = {{(W+2-TW){1'b0}}, t};
			e1 = {{2{v[W-1]}}, v} - {{2{lo[W-1]}}, lo} + tt;
			e2 = {{2{hi[W-1]}}, hi} - {{2{v[W-1]}}, v} + tt;
			return !e1[W+1] && !e2[W+1];
		end
	endfunction

	// stage 1: word taken from the queue
	logic            vld_s1;
	logic [10*W+1:0] dat_s1;

	logic signed [W-1:0] ax1, ay1, ax2, bx1, by1, bx2, sa1, sb1;
	logic                av1, bv1, par1, xok1;
	logic signed [W:0]   ds1, nsb1, dyab1;
	logic [W:0]          ads1;
	sis_pkg::case_code_t code1;
	logic signed [2*W:0]   p1_n;
	logic signed [2*W-1:0] p2_n;

	// stage 2: products
	logic                  vld_s2, xok_s2;
	logic [10*W-1:0]       dat_s2;
	logic signed [2*W:0]   p1_s2;
	logic signed [2*W-1:0] p2_s2;
	logic signed [W+F:0]   base_s2;
	logic signed [W:0]     ds_s2;
	sis_pkg::case_code_t   code_s2;

	// stage 3: numerator of the crossing x
	logic                vld_s3, xok_s3;
	logic [10*W-1:0]     dat_s3;
	logic signed [NW-1:0] n_s3;
	logic signed [W:0]   ds_s3;
	sis_pkg::case_code_t code_s3;

	logic                dv;
	logic signed [W-1:0] dq;
	logic [PW-1:0]       dpay;

	logic [8*W-1:0]      crd4;
	logic signed [W-1:0] sa4, sb4, cx4, s4, x04, y04;
	logic                xok4, set4;
	sis_pkg::case_code_t code4;
	logic signed [W:0]   d4;
	logic signed [2*W:0] prd_n;

	logic                vld_s4, set_s4;
	logic signed [2*W:0] prd_s4;
	logic signed [W-1:0] y0_s4, cx_s4;
	sis_pkg::case_code_t code_s4;
	logic [8*W-1:0]      crd_s4;

	logic signed [2*W:0]   sh5;
	logic signed [2*W+1:0] sum5;
	logic signed [W-1:0]   cy5;

	logic                vld_s5, set_s5;
	logic signed [W-1:0] cy_s5, cx_s5;
	sis_pkg::case_code_t code_s5;
	logic [8*W-1:0]      crd_s5;

	logic signed [W-1:0] rax1, ray1, rax2, ray2, rbx1, rby1, rbx2, rby2;
	logic                hit6;

	logic vld_s6;

	assign en       = !vld_s6 || m_tready;
	assign pop      = en && !q_stat.empty;
	assign m_tvalid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= !q_stat.empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= dv;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_comb begin
		ax1 = dat_s1[0*W +: W];
		ay1 = dat_s1[1*W +: W];
		ax2 = dat_s1[2*W +: W];
		bx1 = dat_s1[4*W +: W];
		by1 = dat_s1[5*W +: W];
		bx2 = dat_s1[6*W +: W];
		sa1 = dat_s1[8*W +: W];
		sb1 = dat_s1[9*W +: W];
		av1 = dat_s1[10*W];
		bv1 = dat_s1[10*W+1];
		ds1   = {sa1[W-1], sa1} - {sb1[W-1], sb1};
		ads1  = ds1[W] ? (~ds1 + {{W{1'b0}}, 1'b1}) : ds1;
		par1  = (ds1 == '0) || (ads1 < {{(W+1-TW){1'b0}}, tolerance});
		nsb1  = {(W+1){1'b0}} - {sb1[W-1], sb1};
		dyab1 = {by1[W-1], by1} - {ay1[W-1], ay1};
		if (!av1 && !bv1) begin
			code1 = par1 ? sis_pkg::CASE_PARALLEL : sis_pkg::CASE_GENERAL;
		end else if (!av1) begin
			code1 = sis_pkg::CASE_B_VERT;
		end else if (!bv1) begin
			code1 = sis_pkg::CASE_A_VERT;
		end else begin
			code1 = sis_pkg::CASE_BOTH_VERT;
		end
		// vertical one's start x must lie in the other's x span, no tolerance
		xok1 = av1 ? in_rng(ax1, bx1, bx2, '0) : in_rng(bx1, ax1, ax2, '0);
		p1_n = nsb1 * bx1;
		p2_n = sa1 * ax1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1  <= q_data;
			dat_s2  <= dat_s1[10*W-1:0];
			p1_s2   <= p1_n;
			p2_s2   <= p2_n;
			base_s2 <= {dyab1, {F{1'b0}}};
			ds_s2   <= ds1;
			code_s2 <= code1;
			xok_s2  <= xok1;
			dat_s3  <= dat_s2;
			n_s3    <= {{(NW-W-1-F){base_s2[W+F]}}, base_s2}
			           + {{2{p1_s2[2*W]}}, p1_s2}
			           + {{3{p2_s2[2*W-1]}}, p2_s2};
			ds_s3   <= ds_s2;
			code_s3 <= code_s2;
			xok_s3  <= xok_s2;
		end
	end

	sis_div #(.NW(NW), .DW(W+1), .QW(W), .PW(PW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.num      (n_s3),
		.den      (ds_s3),
		.pay      ({xok_s3, code_s3, dat_s3}),
		.out_valid(dv),
		.quo      (dq),
		.pay_out  (dpay)
	);

	always_comb begin
		crd4  = dpay[8*W-1:0];
		sa4   = dpay[8*W +: W];
		sb4   = dpay[9*W +: W];
		code4 = sis_pkg::case_code_t'(dpay[10*W +: 3]);
		xok4  = dpay[10*W+3];
		unique case (code4)
			sis_pkg::CASE_GENERAL: begin
				cx4 = dq;  s4 = sa4; x04 = crd4[0*W +: W]; y04 = crd4[1*W +: W]; set4 = 1'b1;
			end
			sis_pkg::CASE_B_VERT: begin
				cx4 = crd4[4*W +: W]; s4 = sa4;
				x04 = crd4[0*W +: W]; y04 = crd4[1*W +: W]; set4 = xok4;
			end
			sis_pkg::CASE_A_VERT: begin
				cx4 = crd4[0*W +: W]; s4 = sb4;
				x04 = crd4[4*W +: W]; y04 = crd4[5*W +: W]; set4 = xok4;
			end
			default: begin
				cx4 = '0; s4 = '0; x04 = '0; y04 = '0; set4 = 1'b0;
			end
		endcase
		d4    = {cx4[W-1], cx4} - {x04[W-1], x04};
		prd_n = s4 * d4;
	end

	always_comb begin
		sh5  = prd_s4 >>> F;
		sum5 = {sh5[2*W], sh5} + {{(W+2){y0_s4[W-1]}}, y0_s4};
		if (sum5 > CMAXW) begin
			cy5 = {1'b0, {(W-1){1'b1}}};
		end else if (sum5 < CMINW) begin
			cy5 = {1'b1, {(W-1){1'b0}}};
		end else begin
			cy5 = sum5[W-1:0];
		end
	end

	always_comb begin
		rax1 = crd_s5[0*W +: W];
		ray1 = crd_s5[1*W +: W];
		rax2 = crd_s5[2*W +: W];
		ray2 = crd_s5[3*W +: W];
		rbx1 = crd_s5[4*W +: W];
		rby1 = crd_s5[5*W +: W];
		rbx2 = crd_s5[6*W +: W];
		rby2 = crd_s5[7*W +: W];
		hit6 = set_s5 && in_rng(cy_s5, ray1, ray2, tolerance)
		       && in_rng(cy_s5, rby1, rby2, tolerance)
		       && ((code_s5 != sis_pkg::CASE_GENERAL)
		           || (in_rng(cx_s5, rax1, rax2, tolerance)
		               && in_rng(cx_s5, rbx1, rbx2, tolerance)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prd_s4    <= prd_n;
			y0_s4     <= y04;
			cx_s4     <= cx4;
			set_s4    <= set4;
			code_s4   <= code4;
			crd_s4    <= crd4;
			cy_s5     <= cy5;
			cx_s5     <= cx_s4;
			set_s5    <= set_s4;
			code_s5   <= code_s4;
			crd_s5    <= crd_s4;
			hit       <= hit6;
			point_set <= set_s5;
			cross_x   <= set_s5 ? cx_s5 : '0;
			cross_y   <= set_s5 ? cy_s5 : '0;
			case_code <= code_s5;
		end
	end

	ap_hit_needs_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hit |-> point_set)
		else $error("hit without a computed point");

	ap_unset_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !point_set |-> (cross_x == '0) && (cross_y == '0))
		else $error("crossing point not cleared");

	ap_no_point_cases: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((case_code == sis_pkg::CASE_PARALLEL)
		             || (case_code == sis_pkg::CASE_BOTH_VERT)) |-> !point_set)
		else $error("point set for parallel or both vertical");

	ap_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_s4))
		else $error("back pipeline moved while stalled");

endmodule

>>> design/segment_intersection_core.sv
`timescale 1ns / 1ps
// Segment crossing test in signed fixed point. Each input word carries two segments A and B;
// each result word carries the hit flag and the crossing point, with point_set and the case
// code on tuser. Throughput is one word per clock while the output is not stalled. The front
// registers the input word and runs the two slope dividers; the back takes the word from the
// queue, forms the products and the crossing-x numerator, runs the crossing divider, then
// projects and range-tests; every divider retires one quotient bit per stage. A four-word queue
// between front and back absorbs output stalls. The tolerance register resets to 1; the user
// must write it through cfg_we / cfg_wdata only while idle; the block does not enforce this.
module segment_intersection_core #(
	parameter int FRAC_BITS   = sis_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = sis_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sis_pkg::TOL_WIDTH-1:0] cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  logic [8*COORD_WIDTH-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hit, cross_x, cross_y, zero fill
	output logic [((2*COORD_WIDTH+8)/8)*8-1:0] m_tdata,
	// point_set, case_code
	output logic [3:0]                    m_tuser
);

	localparam int W    = COORD_WIDTH;
	localparam int OUTW = ((2*W + 8) / 8) * 8;
	localparam int QDW  = 10*W + 2;

	logic [sis_pkg::TOL_WIDTH-1:0] tol_q;
	sis_pkg::q_status_t            q_stat;
	logic                          push, pop;
	logic [QDW-1:0]                push_data, pop_data;
	logic                          hit, point_set;
	logic signed [W-1:0]           cross_x, cross_y;
	sis_pkg::case_code_t           case_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= sis_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	sis_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.tolerance(tol_q),
		.q_full   (q_stat.full),
		.push     (push),
		.push_data(push_data)
	);

	sis_queue #(.DWID(QDW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (q_stat)
	);

	sis_back #(.W(W), .F(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tolerance(tol_q),
		.q_stat   (q_stat),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.hit      (hit),
		.point_set(point_set),
		.cross_x  (cross_x),
		.cross_y  (cross_y),
		.case_code(case_code)
	);

	assign m_tdata = {{(OUTW-2*W-1){1'b0}}, cross_y, cross_x, hit};
	assign m_tuser = {case_code, point_set};

endmodule

>>> bench/tb_segment_intersection_core.sv
`timescale 1ns / 1ps
module tb_segment_intersection_core;

	localparam int FB = 16;
	localparam int CW = 32;
	localparam int LATENCY = 2*CW + 11;
	localparam int NUM_RANDOM = 530;
	localparam longint LIMIT_CYCLES = 400000;
	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;

	typedef struct {
		logic signed [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	} seg_pair_t;

	typedef struct {
		logic hit;
		logic point_set;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		sis_pkg::case_code_t code;
	} crossing_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [sis_pkg::TOL_WIDTH-1:0] cfg_wdata;
	logic s_tvalid, s_tready;
	logic [8*CW-1:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [((2*CW+8)/8)*8-1:0] m_tdata;
	logic [3:0] m_tuser;

	segment_intersection_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	seg_pair_t pair_queue[$];
	crossing_t crossing_queue[$];
	logic [sis_pkg::TOL_WIDTH-1:0] tol_shadow;
	int errors = 0;
	int words_in = 0, words_out = 0, hits_seen = 0;
	int case_counts[5];
	longint cycles = 0;
	bit quiet_send, quiet_recv;
	int hold_off;
	bit hold_done;
	bit in_taken;

	function automatic longint sat_coord(input logic signed [127:0] v);
		if (v < 128'(CMIN)) return CMIN;
		if (v > 128'(CMAX)) return CMAX;
		return longint'(v);
	endfunction

	// truncating divide, saturated to the coordinate range
	function automatic longint div_sat(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] q;
		q = num / den;
		return sat_coord(q);
	endfunction

	function automatic longint proj_y(input longint y0, input longint s, input longint d);
		logic signed [127:0] p;
		p = (128'(s) * 128'(d)) >>> FB;
		return sat_coord(p + 128'(y0));
	endfunction

	function automatic bit within_span(input longint v, input longint p, input longint q,
			input longint t);
		longint lo, hi;
		lo = p < q ? p : q;
		hi = p < q ? q : p;
		return (v - lo >= -t) && (hi - v >= -t);
	endfunction

	function automatic bit is_vertical(input longint dx, input longint t);
		return dx == 0 || (dx < 0 ? -dx : dx) < t;
	endfunction

	function automatic crossing_t predict_crossing(input seg_pair_t sp,
			input logic [sis_pkg::TOL_WIDTH-1:0] tol);
		crossing_t r;
		longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, t, sa, sb, ds, cx, cy;
		logic signed [127:0] n;
		bit av, bv;
		ax1 = sp.ax1; ay1 = sp.ay1; ax2 = sp.ax2; ay2 = sp.ay2;
		bx1 = sp.bx1; by1 = sp.by1; bx2 = sp.bx2; by2 = sp.by2;
		t = tol;
		av = is_vertical(ax2 - ax1, t);
		bv = is_vertical(bx2 - bx1, t);
		sa = av ? 0 : div_sat(128'(ay2 - ay1) <<< FB, 128'(ax2 - ax1));
		sb = bv ? 0 : div_sat(128'(by2 - by1) <<< FB, 128'(bx2 - bx1));
		r.hit = 0; r.point_set = 0; cx = 0; cy = 0;
		if (!av && !bv) begin
			ds = sa - sb;
			if (ds == 0 || (ds < 0 ? -ds : ds) < t) begin
				r.code = sis_pkg::CASE_PARALLEL;
			end else begin
				n = (128'(by1 - ay1) <<< FB) - 128'(sb) * 128'(bx1) + 128'(sa) * 128'(ax1);
				r.code = sis_pkg::CASE_GENERAL;
				cx = div_sat(n, 128'(ds));
				cy = proj_y(ay1, sa, cx - ax1);
				r.point_set = 1;
				r.hit = within_span(cy, ay1, ay2, t) && within_span(cy, by1, by2, t) &&
					within_span(cx, ax1, ax2, t) && within_span(cx, bx1, bx2, t);
			end
		end else if (!av) begin
			r.code = sis_pkg::CASE_B_VERT;
			if (within_span(bx1, ax1, ax2, 0)) begin
				cx = bx1;
				cy = proj_y(ay1, sa, bx1 - ax1);
				r.point_set = 1;
				r.hit = within_span(cy, ay1, ay2, t) && within_span(cy, by1, by2, t);
			end
		end else if (!bv) begin
			r.code = sis_pkg::CASE_A_VERT;
			if (within_span(ax1, bx1, bx2, 0)) begin
				cx = ax1;
				cy = proj_y(by1, sb, ax1 - bx1);
				r.point_set = 1;
				r.hit = within_span(cy, ay1, ay2, t) && within_span(cy, by1, by2, t);
			end
		end else begin
			r.code = sis_pkg::CASE_BOTH_VERT;
		end
		r.cx = cx[CW-1:0];
		r.cy = cy[CW-1:0];
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rnd_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 2097151)) - 32'sd1048576;
			default: return $signed($urandom_range(0, 32767)) - 32'sd16384;
		endcase
	endfunction

	function automatic seg_pair_t rnd_pair();
		seg_pair_t sp;
		int mode, shape;
		mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
		sp.ax1 = rnd_coord(mode); sp.ay1 = rnd_coord(mode);
		sp.ax2 = rnd_coord(mode); sp.ay2 = rnd_coord(mode);
		sp.bx1 = rnd_coord(mode); sp.by1 = rnd_coord(mode);
		sp.bx2 = rnd_coord(mode); sp.by2 = rnd_coord(mode);
		shape = $urandom_range(0, 9);
		// build crossing shapes so that most pairs reach the range tests
		if (shape < 3) begin
			sp.bx1 = sp.ax1 + ((sp.ax2 - sp.ax1) >>> 1);
			sp.by1 = sp.ay1 - 32'sd65536;
			sp.by2 = sp.ay2 + 32'sd65536;
			sp.bx2 = sp.bx1 + $signed(32'($urandom_range(0, 1)));
		end else if (shape == 3) begin
			sp.ax2 = sp.ax1 + $signed(32'($urandom_range(0, 2)));
			sp.bx1 = sp.ax2 - 32'sd65536; sp.bx2 = sp.ax2 + 32'sd65536;
		end else if (shape == 4) begin
			sp.bx2 = sp.bx1 + (sp.ax2 - sp.ax1);
			sp.by2 = sp.by1 + (sp.ay2 - sp.ay1) + $signed(32'($urandom_range(0, 3)));
		end else if (shape == 5) begin
			sp.bx2 = sp.bx1;
		end
		return sp;
	endfunction

	function automatic seg_pair_t mk_pair(input longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
		seg_pair_t sp;
		sp.ax1 = CW'(ax1); sp.ay1 = CW'(ay1); sp.ax2 = CW'(ax2); sp.ay2 = CW'(ay2);
		sp.bx1 = CW'(bx1); sp.by1 = CW'(by1); sp.bx2 = CW'(bx2); sp.by2 = CW'(by2);
		return sp;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else if (!s_tvalid || in_taken) begin
			if (pair_queue.size() > 0 && (quiet_send || $urandom_range(0, 99) >= 10)) begin
				seg_pair_t sp;
				sp = pair_queue.pop_front();
				s_tdata <= {sp.by2, sp.bx2, sp.by1, sp.bx1, sp.ay2, sp.ax2, sp.ay1, sp.ax1};
				s_tvalid <= 1;
				crossing_queue.push_back(predict_crossing(sp, tol_shadow));
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// the handshake is judged at the rising edge, where the word is taken
	always @(posedge clk) begin
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) words_in <= words_in + 1;
	end

	// receiver readiness, with one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else if (!hold_done && words_in > 60) begin
			hold_done <= 1;
			hold_off <= 300;
			m_tready <= 0;
		end else begin
			m_tready <= quiet_recv || $urandom_range(0, 99) >= 10;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			crossing_t got, want;
			got.hit = m_tdata[0];
			got.cx = m_tdata[CW:1];
			got.cy = m_tdata[2*CW:CW+1];
			got.point_set = m_tuser[0];
			got.code = sis_pkg::case_code_t'(m_tuser[3:1]);
			words_out <= words_out + 1;
			if (crossing_queue.size() == 0) begin
				errors <= errors + 1;
				if (errors < 10) $display("unexpected result word at cycle %0d", cycles);
			end else begin
				want = crossing_queue.pop_front();
				if (got.hit !== want.hit || got.point_set !== want.point_set ||
						got.cx !== want.cx || got.cy !== want.cy || got.code !== want.code) begin
					errors <= errors + 1;
					if (errors < 10) begin
						$display("mismatch: exp hit=%0b set=%0b x=%0d y=%0d case=%0d",
							want.hit, want.point_set, want.cx, want.cy, want.code);
						$display("          got hit=%0b set=%0b x=%0d y=%0d case=%0d",
							got.hit, got.point_set, got.cx, got.cy, got.code);
					end
				end
				if (want.hit) hits_seen <= hits_seen + 1;
				case_counts[want.code] <= case_counts[want.code] + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout with %0d results outstanding", crossing_queue.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic drain();
		wait (pair_queue.size() == 0 && crossing_queue.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [sis_pkg::TOL_WIDTH-1:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		tol_shadow <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(input int count);
		repeat (count) pair_queue.push_back(rnd_pair());
		drain();
	endtask

	initial begin
		longint mx, mn;
		mx = CMAX; mn = CMIN;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; s_tdata = '0;
		s_tvalid = 0; m_tready = 0;
		tol_shadow = sis_pkg::TOL_RESET;
		quiet_send = 0; quiet_recv = 0; hold_off = 0; hold_done = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// general crossing, parallel, each vertical, both vertical, zero length
		pair_queue.push_back(mk_pair(0, 0, 65536*4, 65536*4, 0, 65536*4, 65536*4, 0));
		pair_queue.push_back(mk_pair(0, 0, 65536, 65536, 0, 65536, 65536, 65536*2));
		pair_queue.push_back(mk_pair(0, 0, 65536*4, 65536*4, 65536, -65536, 65536, 65536*8));
		pair_queue.push_back(mk_pair(65536, -65536, 65536, 65536*8, 0, 0, 65536*4, 65536*4));
		pair_queue.push_back(mk_pair(65536, 0, 65536, 65536, 0, 0, 0, 65536));
		pair_queue.push_back(mk_pair(5, 5, 5, 5, 0, 0, 65536*4, 65536*4));
		// vertical x outside the other span
		pair_queue.push_back(mk_pair(0, 0, 65536, 65536, 65536*9, 0, 65536*9, 65536));
		// crossing point off both segments
		pair_queue.push_back(mk_pair(0, 0, 65536, 65536, 65536*9, 0, 65536*10, -65536));
		// extremes and saturating slopes
		pair_queue.push_back(mk_pair(mn, mn, mx, mx, mn, mx, mx, mn));
		pair_queue.push_back(mk_pair(0, mn, 1, mx, 0, mx, 1, mn));
		pair_queue.push_back(mk_pair(mx, mx, mx, mx, mn, mn, mn, mn));
		pair_queue.push_back(mk_pair(-1, -1, -1, -1, -1, -1, -1, -1));
		pair_queue.push_back(mk_pair(mn, 0, mx, 1, mn, 1, mx, 0));
		pair_queue.push_back(mk_pair(0, 0, 2, mx, 0, mx, 2, mn));
		drain();
		write_tolerance(0);
		pair_queue.push_back(mk_pair(0, 0, 1, 0, 0, 0, 0, 65536));
		pair_queue.push_back(mk_pair(0, 0, 65536, 65536, 0, 65536, 65536, 65536*2));
		random_phase(120);
		write_tolerance(16'hFFFF);
		pair_queue.push_back(mk_pair(0, 0, 65535, 65536, 0, 0, 65536*3, 1));
		random_phase(120);
		write_tolerance(16'd64);
		quiet_send = 1; quiet_recv = 1;
		random_phase(100);
		quiet_send = 0; quiet_recv = 0;
		write_tolerance(16'($urandom_range(0, 65535)));
		random_phase(90);
		write_tolerance(sis_pkg::TOL_RESET);
		random_phase(NUM_RANDOM - 430);

		$display("covered %0d words in, %0d out, %0d hits", words_in, words_out, hits_seen);
		$display("cases general/parallel/b-vert/a-vert/both: %0d %0d %0d %0d %0d",
			case_counts[0], case_counts[1], case_counts[2], case_counts[3], case_counts[4]);
		if (errors == 0 && crossing_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
